// ===== rtl/pcc_pkg.sv =====
// pcc_pkg: shared types and constants for the path pair conflict checker
// holds the transfer structs, opcode and register index codes, field widths
// no dependencies
`default_nettype none

package pcc_pkg;

    localparam int LocW    = 16;
    localparam int WinW    = 6;
    localparam int MarginW = 3;
    localparam int StepW   = 6;
    localparam int OpW     = 2;
    localparam int CfgIdxW = 1;
    localparam int CfgW    = 6;

    // opcodes of an input transfer
    localparam logic [OpW-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OpW-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OpW-1:0] OP_CHECK    = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MARGIN = 1'd1;

    localparam logic [WinW-1:0]    WindowReset = 6'd63;
    localparam logic [MarginW-1:0] MarginReset = 3'd0;

    // conflict kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_EDGE   = 1'b1;

    typedef struct packed {
        logic [OpW-1:0]  opcode;
        logic [LocW-1:0] location;
        logic            loc_is_special;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic             conflict_kind;
        logic [LocW-1:0]  first_loc;
        logic [LocW-1:0]  second_loc;
        logic [StepW-1:0] conflict_step;
    } out_item_t;

    // status of the scan sequencer toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } scan_status_t;

endpackage

`default_nettype wire

// ===== rtl/pcc_path_mem.sv =====
// pcc_path_mem: one write port, one registered read port path store
// used for the path A and path B step memories; no package dependency
`default_nettype none

module pcc_path_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcc_scan.sv =====
// pcc_scan: sequencer that walks the two stored paths for the first conflict
// drives the read ports of both path memories; uses pcc_pkg
`default_nettype none

module pcc_scan #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [((($clog2(MAX_STEPS+1)) > 7) ?
                        $clog2(MAX_STEPS+1) : 7)-1:0] size1,
    input  wire logic [((($clog2(MAX_STEPS+1)) > 7) ?
                        $clog2(MAX_STEPS+1) : 7)-1:0] size2,
    input  wire logic [pcc_pkg::MarginW-1:0]         margin,
    input  wire logic                                res_ack,
    output pcc_pkg::scan_status_t                    status,
    output pcc_pkg::out_item_t                       result,
    output logic                                     a_rd_en,
    output logic [$clog2(MAX_STEPS)-1:0]             a_rd_addr,
    input  wire logic [pcc_pkg::LocW:0]              a_rd_data,
    output logic                                     b_rd_en,
    output logic [$clog2(MAX_STEPS)-1:0]             b_rd_addr,
    input  wire logic [pcc_pkg::LocW-1:0]            b_rd_data
);

    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int SW = (LW > 7) ? LW : 7;
    localparam int CW = SW + 1;
    localparam int AW = $clog2(MAX_STEPS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_VCMP = 5'b00100,
        S_ECMP = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [SW-1:0]                 size1_reg, size1_next;
    logic [SW-1:0]                 size2_reg, size2_next;
    logic [pcc_pkg::MarginW-1:0]   k_reg, k_next;
    logic [SW-1:0]                 t_reg, t_next;
    logic [SW-1:0]                 i_reg, i_next;
    logic [SW-1:0]                 hi_reg, hi_next;
    logic [pcc_pkg::LocW-1:0]      a_prev_reg, a_prev_next;
    logic [pcc_pkg::LocW-1:0]      b_prev_reg, b_prev_next;
    pcc_pkg::out_item_t            res_reg, res_next;

    logic [pcc_pkg::LocW-1:0]      a_loc;
    logic                          a_special;
    logic [SW-1:0]                 k_ext;
    logic [CW-1:0]                 t_plus_k;
    logic [CW-1:0]                 size2_m1;
    logic [SW-1:0]                 lo;
    logic                          stop;
    logic                          vmatch;
    logic                          edge_ok;
    logic                          swap;

    assign a_loc     = a_rd_data[pcc_pkg::LocW:1];
    assign a_special = a_rd_data[0];
    assign k_ext     = SW'(k_reg);
    assign t_plus_k  = CW'(t_reg) + CW'(k_reg);
    assign size2_m1  = CW'(size2_reg) - CW'(1);
    assign lo        = (t_reg >= k_ext) ? (t_reg - k_ext) : '0;
    // path A exhausted, or path B ended more than k steps back
    assign stop      = (t_reg >= size1_reg) || (CW'(t_reg) >= CW'(size2_reg) + CW'(k_reg));
    assign vmatch    = (size2_reg != '0) && (a_loc == b_rd_data) && !a_special;
    assign edge_ok   = (k_reg == '0) && (CW'(t_reg) + CW'(1) < CW'(size1_reg))
                       && (CW'(t_reg) + CW'(1) < CW'(size2_reg));
    assign swap      = (a_prev_reg != b_prev_reg) && (a_prev_reg == b_rd_data)
                       && (b_prev_reg == a_loc);

    always_comb
    begin
        state_next  = state_reg;
        size1_next  = size1_reg;
        size2_next  = size2_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        i_next      = i_reg;
        hi_next     = hi_reg;
        a_prev_next = a_prev_reg;
        b_prev_next = b_prev_reg;
        res_next    = res_reg;
        a_rd_en     = 1'b0;
        b_rd_en     = 1'b0;
        a_rd_addr   = AW'(t_reg);
        b_rd_addr   = AW'(lo);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size1_next = size1;
                    size2_next = size2;
                    k_next     = margin;
                    t_next     = '0;
                    res_next   = '0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stop)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    a_rd_en    = 1'b1;
                    b_rd_en    = 1'b1;
                    i_next     = lo;
                    hi_next    = (t_plus_k > size2_m1) ? SW'(size2_m1) : SW'(t_plus_k);
                    state_next = S_VCMP;
                end
            end
            S_VCMP:
            begin
                if (vmatch)
                begin
                    res_next.found         = 1'b1;
                    res_next.conflict_kind = pcc_pkg::KIND_VERTEX;
                    res_next.first_loc     = a_loc;
                    res_next.second_loc    = '0;
                    res_next.conflict_step = (i_reg < t_reg) ? pcc_pkg::StepW'(i_reg)
                                                             : pcc_pkg::StepW'(t_reg);
                    state_next             = S_DONE;
                end
                else if ((size2_reg != '0) && (i_reg < hi_reg))
                begin
                    b_rd_en   = 1'b1;
                    b_rd_addr = AW'(i_reg + SW'(1));
                    i_next    = i_reg + SW'(1);
                end
                else if (edge_ok)
                begin
                    // keep step t, fetch step t+1 of both paths
                    a_rd_en     = 1'b1;
                    b_rd_en     = 1'b1;
                    a_rd_addr   = AW'(t_reg + SW'(1));
                    b_rd_addr   = AW'(t_reg + SW'(1));
                    a_prev_next = a_loc;
                    b_prev_next = b_rd_data;
                    state_next  = S_ECMP;
                end
                else
                begin
                    t_next     = t_reg + SW'(1);
                    state_next = S_STEP;
                end
            end
            S_ECMP:
            begin
                if (swap)
                begin
                    res_next.found         = 1'b1;
                    res_next.conflict_kind = pcc_pkg::KIND_EDGE;
                    res_next.first_loc     = a_prev_reg;
                    res_next.second_loc    = b_prev_reg;
                    res_next.conflict_step = pcc_pkg::StepW'(t_reg + SW'(1));
                    state_next             = S_DONE;
                end
                else
                begin
                    t_next     = t_reg + SW'(1);
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size1_reg  <= size1_next;
        size2_reg  <= size2_next;
        k_reg      <= k_next;
        t_reg      <= t_next;
        i_reg      <= i_next;
        hi_reg     <= hi_next;
        a_prev_reg <= a_prev_next;
        b_prev_reg <= b_prev_next;
        res_reg    <= res_next;
    end

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_DONE);
    assign result      = res_reg;

    // path B reads stay inside the scan window and the stored length
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VCMP) && (size2_reg != '0) |-> (i_reg <= hi_reg) && (i_reg < size2_reg))
        else $error("vertex scan index out of range");

    // a step under comparison is always a stored step of path A
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VCMP) || (state_reg == S_ECMP) |-> (t_reg < size1_reg))
        else $error("step index beyond path A");

    // edge compare only runs with a zero margin
    a_edge_margin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ECMP) |-> (k_reg == '0) && $past(state_reg == S_VCMP))
        else $error("edge compare entered with nonzero margin");

endmodule

`default_nettype wire

// ===== rtl/path_pair_conflict_check.sv =====
// path_pair_conflict_check: top level with path stores, lengths, config and output register
// depends on pcc_pkg, pcc_path_mem and pcc_scan
`default_nettype none

// usage
//   input channel (in_valid, in_stall, in_item): each transfer is an append to
//   path A, an append to path B, or a check; appends are taken one per cycle
//   while in_stall is low and can follow back to back; an append to a full
//   path is dropped; a check walks the stored paths step by step and produces
//   exactly one transfer on the output channel (out_valid, out_stall, out_item)
//   check walk: per path A step, a step state, then a vertex scan of at most
//   2k+1 path B entries (one per cycle through the single read port of the B
//   memory, clipped at the ends of path B), then an edge compare when k is
//   zero; the walk ends at the first conflict or after min(len A, window+1)
//   steps, earlier once path B ended more than k steps back; the result is
//   then handed to the output register
//   in_stall is high from a check transfer until its result sits in the
//   output register; both lengths are zero again after a check
//   a stalled result waits in the output register while new appends are taken;
//   the result of a further check then waits in the sequencer, in_stall high
//   configuration: cfg_wr_en with cfg_index and cfg_wdata, write only while idle
//   reset: lengths cleared, window 63, margin 0, no output pending; the path
//   memories need no clearing since only entries below the length are used

module path_pair_conflict_check #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire pcc_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output pcc_pkg::out_item_t                out_item,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pcc_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pcc_pkg::CfgW-1:0]     cfg_wdata
);

    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int SW = (LW > 7) ? LW : 7;
    localparam int AW = $clog2(MAX_STEPS);

    logic [LW-1:0]                   len_a_reg, len_a_next;
    logic [LW-1:0]                   len_b_reg, len_b_next;
    logic [pcc_pkg::WinW-1:0]        window_reg, window_next;
    logic [pcc_pkg::MarginW-1:0]     margin_reg, margin_next;
    logic                            out_valid_reg, out_valid_next;
    pcc_pkg::out_item_t              out_data_reg;

    logic                            in_xfer;
    logic                            wr_a;
    logic                            wr_b;
    logic                            start;
    logic [SW-1:0]                   lim;
    logic [SW-1:0]                   size1;
    logic [SW-1:0]                   size2;
    logic                            res_load;
    pcc_pkg::scan_status_t           status;
    pcc_pkg::out_item_t              result;
    logic                            a_rd_en;
    logic [AW-1:0]                   a_rd_addr;
    logic [pcc_pkg::LocW:0]          a_rd_data;
    logic                            b_rd_en;
    logic [AW-1:0]                   b_rd_addr;
    logic [pcc_pkg::LocW-1:0]        b_rd_data;

    // input side: open only while the sequencer is idle
    assign in_stall = !status.idle;
    assign in_xfer  = in_valid && !in_stall;
    assign wr_a     = in_xfer && (in_item.opcode == pcc_pkg::OP_APPEND_A)
                      && (len_a_reg < LW'(MAX_STEPS));
    assign wr_b     = in_xfer && (in_item.opcode == pcc_pkg::OP_APPEND_B)
                      && (len_b_reg < LW'(MAX_STEPS));
    assign start    = in_xfer && (in_item.opcode == pcc_pkg::OP_CHECK);

    // compared lengths are clipped to window plus one
    assign lim   = SW'(window_reg) + SW'(1);
    assign size1 = (SW'(len_a_reg) < lim) ? SW'(len_a_reg) : lim;
    assign size2 = (SW'(len_b_reg) < lim) ? SW'(len_b_reg) : lim;

    always_comb
    begin
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        if (start)
        begin
            len_a_next = '0;
            len_b_next = '0;
        end
        else
        begin
            if (wr_a)
            begin
                len_a_next = len_a_reg + LW'(1);
            end
            if (wr_b)
            begin
                len_b_next = len_b_reg + LW'(1);
            end
        end
    end

    // configuration writes
    always_comb
    begin
        window_next = window_reg;
        margin_next = margin_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pcc_pkg::CFG_WINDOW: window_next = cfg_wdata[pcc_pkg::WinW-1:0];
                pcc_pkg::CFG_MARGIN: margin_next = cfg_wdata[pcc_pkg::MarginW-1:0];
                default:             window_next = window_reg;
            endcase
        end
    end

    // output register: takes the result when empty or being drained
    assign res_load = status.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            window_reg    <= pcc_pkg::WindowReset;
            margin_reg    <= pcc_pkg::MarginReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            window_reg    <= window_next;
            margin_reg    <= margin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

    // path A store keeps the special flag in the low bit
    pcc_path_mem #(
        .DEPTH (MAX_STEPS),
        .WIDTH (pcc_pkg::LocW + 1)
    ) u_mem_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (AW'(len_a_reg)),
        .wr_data ({in_item.location, in_item.loc_is_special}),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    pcc_path_mem #(
        .DEPTH (MAX_STEPS),
        .WIDTH (pcc_pkg::LocW)
    ) u_mem_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (AW'(len_b_reg)),
        .wr_data (in_item.location),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    pcc_scan #(
        .MAX_STEPS (MAX_STEPS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .size1     (size1),
        .size2     (size2),
        .margin    (margin_reg),
        .res_ack   (res_load),
        .status    (status),
        .result    (result),
        .a_rd_en   (a_rd_en),
        .a_rd_addr (a_rd_addr),
        .a_rd_data (a_rd_data),
        .b_rd_en   (b_rd_en),
        .b_rd_addr (b_rd_addr),
        .b_rd_data (b_rd_data)
    );

    // lengths never pass the store depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_a_reg <= LW'(MAX_STEPS)) && (len_b_reg <= LW'(MAX_STEPS)))
        else $error("path length beyond store depth");

    // a result without a conflict carries all-zero fields
    a_clean_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.found |-> (out_data_reg == '0))
        else $error("no-conflict result with nonzero fields");

    // a check transfer clears both lengths and starts the scan on the next cycle
    a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (len_a_reg == '0) && (len_b_reg == '0) && !status.idle)
        else $error("check did not clear lengths or start the scan");

endmodule

`default_nettype wire
